FILE: src/tsdf_pkg.sv
// Shared types and constants of the text stream display filter.
package tsdf_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_NUMBER_MODE      = 3'd0;
    localparam logic [2:0] CFG_SQUEEZE          = 3'd1;
    localparam logic [2:0] CFG_MARK_EOL         = 3'd2;
    localparam logic [2:0] CFG_CARET_TAB        = 3'd3;
    localparam logic [2:0] CFG_SHOW_NONPRINTING = 3'd4;

    // Numbering mode that numbers every line; bit 1 set means non-blank lines only.
    localparam logic [1:0] NUM_MODE_ALL = 2'd1;

    // Character codes.
    localparam logic [7:0] CHAR_NL     = 8'd10;
    localparam logic [7:0] CHAR_TAB    = 8'd9;
    localparam logic [7:0] CHAR_SPACE  = 8'd32;
    localparam logic [7:0] CHAR_DOLLAR = 8'd36;
    localparam logic [7:0] CHAR_CARET  = 8'd94;
    localparam logic [7:0] CHAR_ZERO   = 8'd48;
    localparam logic [7:0] CHAR_DEL    = 8'd127;
    localparam logic [7:0] CARET_SHIFT = 8'd64;

    // Number of decimal digits in the line number field.
    localparam int NUM_DIGITS = 6;

    // Slots of one expanded output sequence, emitted in this order.
    localparam int POS_NUM0    = 0;   // first of six number characters
    localparam int POS_NUM_TAB = 6;   // tab after the number
    localparam int POS_PAD0    = 7;   // first of six spaces of a blank-line pad
    localparam int POS_PAD_TAB = 13;  // tab after the pad
    localparam int POS_DOLLAR  = 14;  // end-of-line mark
    localparam int POS_CARET   = 15;  // caret of a shown control byte
    localparam int POS_CHAR    = 16;  // the byte itself, always present
    localparam int NUM_POS     = 17;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_empty;
        logic       mark_eol;
        logic       caret_tab;
        logic       show_nonprinting;
    } t_cfg;

    // One classified input item, waiting to be expanded into output bytes.
    typedef struct packed {
        logic [NUM_POS-1:0]          slots;
        logic [0:NUM_DIGITS-1][7:0]  num_chars;
        logic [7:0]                  final_byte;
    } t_desc;

endpackage

FILE: src/tsdf_front.sv
// Front end: accepts input bytes, keeps per-file line state and classifies each byte.
module tsdf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tsdf_pkg::t_cfg    i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_in_byte,
    input  logic              i_file_start,
    input  logic              i_q_ready,
    output logic              o_q_push,
    output tsdf_pkg::t_desc   o_q_desc
);

    logic                                    r_prev_nl;
    logic                                    r_blank;
    logic [0:tsdf_pkg::NUM_DIGITS-1][3:0]    r_bcd;

    logic                                    n_prev_nl;
    logic                                    n_blank;
    logic [0:tsdf_pkg::NUM_DIGITS-1][3:0]    n_bcd;

    logic                                    accept;
    logic                                    prev_nl;
    logic                                    blank_eff;
    logic [0:tsdf_pkg::NUM_DIGITS-1][3:0]    bcd_eff;
    logic [0:tsdf_pkg::NUM_DIGITS-1][3:0]    bcd_inc;
    logic [0:tsdf_pkg::NUM_DIGITS-1][3:0]    bcd_next;
    logic                                    is_nl;
    logic                                    is_tab;
    logic                                    drop;
    logic                                    new_blank;
    logic                                    do_num;
    logic                                    saturated;
    logic                                    carry;
    logic                                    lead;
    logic                                    tab_caret;
    logic                                    np_caret;
    logic [7:0]                              c2;
    logic [7:0]                              c3;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid & i_q_ready;

    always_comb begin
        // A file start resets the line state before this byte is looked at.
        prev_nl   = i_file_start | r_prev_nl;
        blank_eff = ~i_file_start & r_blank;
        bcd_eff   = i_file_start ? '0 : r_bcd;

        is_nl  = (i_in_byte == tsdf_pkg::CHAR_NL);
        is_tab = (i_in_byte == tsdf_pkg::CHAR_TAB);

        drop      = i_cfg.squeeze_empty & prev_nl & is_nl & blank_eff;
        new_blank = prev_nl & is_nl;
        do_num    = prev_nl & ((i_cfg.number_mode == tsdf_pkg::NUM_MODE_ALL) |
                               (i_cfg.number_mode[1] & ~is_nl));

        // Decimal counter kept in BCD so the number needs no division.
        saturated = 1'b1;
        carry     = 1'b1;
        bcd_inc   = bcd_eff;
        for (int i = 0; i < tsdf_pkg::NUM_DIGITS; i++) begin
            saturated = saturated & (bcd_eff[i] == 4'd9);
        end
        for (int i = tsdf_pkg::NUM_DIGITS - 1; i >= 0; i--) begin
            if (carry) begin
                if (bcd_eff[i] == 4'd9) begin
                    bcd_inc[i] = 4'd0;
                end else begin
                    bcd_inc[i] = bcd_eff[i] + 4'd1;
                    carry      = 1'b0;
                end
            end
        end
        bcd_next = (do_num & ~saturated) ? bcd_inc : bcd_eff;

        // Leading zeros print as spaces; the ones digit always prints.
        lead = 1'b1;
        for (int i = 0; i < tsdf_pkg::NUM_DIGITS; i++) begin
            lead = lead & (bcd_next[i] == 4'd0) & (i != tsdf_pkg::NUM_DIGITS - 1);
            o_q_desc.num_chars[i] = lead ? tsdf_pkg::CHAR_SPACE
                                         : (tsdf_pkg::CHAR_ZERO | {4'd0, bcd_next[i]});
        end

        tab_caret = i_cfg.caret_tab & is_tab;
        c2        = tab_caret ? (tsdf_pkg::CHAR_TAB + tsdf_pkg::CARET_SHIFT) : i_in_byte;
        np_caret  = i_cfg.show_nonprinting & (c2 != tsdf_pkg::CHAR_NL) &
                    (c2 != tsdf_pkg::CHAR_TAB) &
                    ((c2 < tsdf_pkg::CHAR_SPACE) | (c2 >= tsdf_pkg::CHAR_DEL));
        if (np_caret) begin
            c3 = (c2 < tsdf_pkg::CHAR_SPACE) ? (c2 + tsdf_pkg::CARET_SHIFT)
                                             : (c2 - tsdf_pkg::CARET_SHIFT);
        end else begin
            c3 = c2;
        end

        o_q_desc.slots = '0;
        for (int i = tsdf_pkg::POS_NUM0; i <= tsdf_pkg::POS_NUM_TAB; i++) begin
            o_q_desc.slots[i] = do_num;
        end
        for (int i = tsdf_pkg::POS_PAD0; i <= tsdf_pkg::POS_PAD_TAB; i++) begin
            o_q_desc.slots[i] = i_cfg.mark_eol & is_nl & i_cfg.number_mode[1] & new_blank;
        end
        o_q_desc.slots[tsdf_pkg::POS_DOLLAR] = i_cfg.mark_eol & is_nl;
        o_q_desc.slots[tsdf_pkg::POS_CARET]  = tab_caret | np_caret;
        o_q_desc.slots[tsdf_pkg::POS_CHAR]   = 1'b1;
        o_q_desc.final_byte                  = c3;

        o_q_push = accept & ~drop;

        // A squeezed newline leaves the state as it stood.
        if (drop) begin
            n_prev_nl = prev_nl;
            n_blank   = blank_eff;
            n_bcd     = bcd_eff;
        end else begin
            n_prev_nl = is_nl;
            n_blank   = new_blank;
            n_bcd     = bcd_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_nl <= 1'b1;
            r_blank   <= 1'b0;
            r_bcd     <= '0;
        end else if (accept) begin
            r_prev_nl <= n_prev_nl;
            r_blank   <= n_blank;
            r_bcd     <= n_bcd;
        end
    end

endmodule

FILE: src/tsdf_queue.sv
// Short descriptor queue between the front end and the expander.
module tsdf_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tsdf_pkg::t_desc   i_desc,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output tsdf_pkg::t_desc   o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tsdf_pkg::t_desc   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push & ~do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop & ~do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // The front end only pushes while there is room.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("descriptor pushed into a full queue");

    // The expander only pops a present entry.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("descriptor popped from an empty queue");

endmodule

FILE: src/tsdf_back.sv
// Expander: emits the head descriptor's slots, a byte per cycle unless stalled.
module tsdf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  tsdf_pkg::t_desc   i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_last
);

    logic [tsdf_pkg::NUM_POS-1:0]  r_done;
    logic                          r_out_valid;
    logic [7:0]                    r_out_byte;
    logic                          r_out_last;

    logic [tsdf_pkg::NUM_POS-1:0]  remain;
    logic [tsdf_pkg::NUM_POS-1:0]  sel;
    logic [7:0]                    pos_byte [tsdf_pkg::NUM_POS];
    logic [7:0]                    sel_byte;
    logic                          sel_last;
    logic                          load;

    always_comb begin
        for (int k = 0; k < tsdf_pkg::NUM_DIGITS; k++) begin
            pos_byte[tsdf_pkg::POS_NUM0 + k] = i_head.num_chars[k];
            pos_byte[tsdf_pkg::POS_PAD0 + k] = tsdf_pkg::CHAR_SPACE;
        end
        pos_byte[tsdf_pkg::POS_NUM_TAB] = tsdf_pkg::CHAR_TAB;
        pos_byte[tsdf_pkg::POS_PAD_TAB] = tsdf_pkg::CHAR_TAB;
        pos_byte[tsdf_pkg::POS_DOLLAR]  = tsdf_pkg::CHAR_DOLLAR;
        pos_byte[tsdf_pkg::POS_CARET]   = tsdf_pkg::CHAR_CARET;
        pos_byte[tsdf_pkg::POS_CHAR]    = i_head.final_byte;

        // Lowest slot still to be emitted.
        remain = i_head.slots & ~r_done;
        sel    = remain & (~remain + tsdf_pkg::NUM_POS'(1));
        sel_last = ((remain & ~sel) == '0);
        sel_byte = '0;
        for (int k = 0; k < tsdf_pkg::NUM_POS; k++) begin
            sel_byte = sel_byte | (sel[k] ? pos_byte[k] : 8'd0);
        end

        load  = i_head_valid & (~r_out_valid | i_out_ready);
        o_pop = load & sel_last;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= sel_byte;
            r_out_last <= sel_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_done      <= sel_last ? '0 : (r_done | sel);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;

    // The byte itself closes every sequence, so it is never marked done.
    a_char_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_done[tsdf_pkg::POS_CHAR])
        else $error("final byte slot marked done");

    // A partly emitted sequence always belongs to a present head descriptor.
    a_done_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done != '0) |-> i_head_valid)
        else $error("expansion in progress without a head descriptor");

endmodule

FILE: src/text_stream_display_filter.sv
// Top level of the text stream display filter: configuration registers and the three stages.
//
//  Channel   Direction  Handshake                    Payload
//  -------   ---------  ---------------------------  ---------------------------
//  in        input      i_in_valid / o_in_ready      i_in_byte, i_file_start
//  out       output     o_out_valid / i_out_ready    o_out_byte, o_last
//  cfg       input      i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
//  Each input byte produces one to nine output bytes (a squeezed blank line produces none).
//  The expander emits one output byte per cycle while the output is ready, so a byte that
//  expands to n bytes holds the output for all n of them; plain bytes stream at one per cycle.
//  The descriptor queue between front end and expander holds QUEUE_DEPTH transactions and
//  lets the input keep flowing while a long expansion drains.
//  Synchronous active-low reset resets configuration, line state, queue and the output valid flag.
//  A stalled output holds its byte while the front end keeps accepting until the queue fills.
module text_stream_display_filter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_file_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);

    tsdf_pkg::t_cfg   r_cfg;
    tsdf_pkg::t_desc  push_desc;
    tsdf_pkg::t_desc  head_desc;
    logic             q_push;
    logic             q_ready;
    logic             q_valid;
    logic             q_pop;

    // Configuration writes land directly; writes to unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tsdf_pkg::CFG_NUMBER_MODE:      r_cfg.number_mode      <= i_cfg_data;
                tsdf_pkg::CFG_SQUEEZE:          r_cfg.squeeze_empty    <= i_cfg_data[0];
                tsdf_pkg::CFG_MARK_EOL:         r_cfg.mark_eol         <= i_cfg_data[0];
                tsdf_pkg::CFG_CARET_TAB:        r_cfg.caret_tab        <= i_cfg_data[0];
                tsdf_pkg::CFG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The front end classifies each byte and updates the line number and blank state
    // in the cycle the transaction is accepted.
    tsdf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_file_start (i_file_start),
        .i_q_ready    (q_ready),
        .o_q_push     (q_push),
        .o_q_desc     (push_desc)
    );

    tsdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (push_desc),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (head_desc)
    );

    // The expander turns each descriptor into its byte sequence through a registered output.
    tsdf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (head_desc),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last)
    );

endmodule

FILE: verif/text_stream_display_filter_tb.sv
// Self-checking testbench for the text stream display filter: directed table, then random text.
`timescale 1ns / 1ps

module text_stream_display_filter_tb;

    // Cycles allowed for an item that produces no output to clear the pipeline and queue.
    localparam int DRAIN_CYCLES = 24;
    localparam int NUM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 51;
    localparam int MAX_REPORTS = 40;
    localparam int MAX_OUT_BYTES = 9;
    // Register index outside the register map; a write to it must change nothing.
    localparam logic [2:0] CFG_SPARE_INDEX = 3'd7;
    localparam logic [19:0] LINE_COUNT_MAX = 20'd999999;
    localparam tsdf_pkg::t_cfg CFG_NONE = '0;

    // One predicted output byte and its end-of-sequence flag.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_disp_byte;

    // One row of the directed table. A row may first load a new configuration. When
    // typed is set the expected bytes come from the row itself, otherwise from the predictor.
    typedef struct packed {
        logic            new_cfg;
        tsdf_pkg::t_cfg  cfg;
        logic [7:0]      in_byte;
        logic            file_start;
        logic            typed;
        logic [3:0]      n_exp;
        logic [0:8][7:0] exp_bytes;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = tsdf_pkg::CFG_NUMBER_MODE;
    logic [1:0] i_cfg_data = 2'd0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_in_byte = 8'd0;
    logic       i_file_start = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_last;

    text_stream_display_filter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_file_start (i_file_start),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: its own copy of the configuration and the per-file line state.
    tsdf_pkg::t_cfg pcfg;
    logic [7:0]     prev_char;
    logic [19:0]    line_count;
    logic           blank_seen;

    // Output bytes of the transaction being predicted, and all bytes still owed by the block.
    t_disp_byte line_out[$];
    t_disp_byte predicted_display_q[$];

    t_dir_row dir_rows[$];

    int mismatches = 0;
    int n_sent = 0;
    int n_directed = 0;
    int n_checked = 0;
    int n_squeezed = 0;
    int n_phases = 0;
    int max_line = 0;

    // Sender burst shaping and random text state.
    int burst_left = 0;
    bit no_gaps = 1'b0;
    int nl_run = 0;

    // Receiver stall pattern state.
    int rx_hold_left = 0;
    int rx_mode = 0;

    t_disp_byte seen_want;

    function automatic tsdf_pkg::t_cfg mk_cfg(input logic [1:0] nm, input logic sq,
                                              input logic se, input logic st,
                                              input logic sn);
        tsdf_pkg::t_cfg c;
        c.number_mode = nm;
        c.squeeze_empty = sq;
        c.mark_eol = se;
        c.caret_tab = st;
        c.show_nonprinting = sn;
        return c;
    endfunction

    function automatic t_dir_row mk_row(input logic new_cfg, input tsdf_pkg::t_cfg c,
                                        input logic [7:0] b, input logic fs,
                                        input logic typed, input string txt);
        t_dir_row r;
        int i;
        r = '0;
        r.new_cfg = new_cfg;
        r.cfg = c;
        r.in_byte = b;
        r.file_start = fs;
        r.typed = typed;
        r.n_exp = 4'(txt.len());
        for (i = 0; i < txt.len() && i < MAX_OUT_BYTES; i++) begin
            r.exp_bytes[i] = txt[i];
        end
        return r;
    endfunction

    function void emit_char(input logic [7:0] ch);
        t_disp_byte e;
        if (line_out.size() < MAX_OUT_BYTES) begin
            e.ch = ch;
            e.last = 1'b0;
            line_out.push_back(e);
        end
    endfunction

    // Works out the display bytes of one input byte and advances the line state.
    function void predict_display(input logic [7:0] in_b, input logic fs);
        logic [7:0]  c;
        logic        nb_mode;
        logic        all_mode;
        logic        prev_nl;
        logic [19:0] v;
        logic [7:0]  digits [0:5];
        int          k;
        line_out.delete();
        c = in_b;
        // Bit 1 alone picks non-blank numbering, so mode three behaves like mode two.
        nb_mode = pcfg.number_mode[1];
        all_mode = pcfg.number_mode == tsdf_pkg::NUM_MODE_ALL;
        if (fs) begin
            prev_char = tsdf_pkg::CHAR_NL;
            line_count = '0;
            blank_seen = 1'b0;
        end
        prev_nl = prev_char == tsdf_pkg::CHAR_NL;
        // A second empty line in a row vanishes without touching any state.
        if (pcfg.squeeze_empty && prev_nl && c == tsdf_pkg::CHAR_NL && blank_seen) begin
            n_squeezed++;
            return;
        end
        blank_seen = prev_nl && c == tsdf_pkg::CHAR_NL;
        if (prev_nl && (all_mode || (nb_mode && c != tsdf_pkg::CHAR_NL))) begin
            // The line counter holds at its maximum and repeats that number.
            if (line_count < LINE_COUNT_MAX) begin
                line_count++;
            end
            v = line_count;
            for (k = 0; k < tsdf_pkg::NUM_DIGITS; k++) begin
                digits[k] = tsdf_pkg::CHAR_SPACE;
            end
            k = tsdf_pkg::NUM_DIGITS - 1;
            do begin
                digits[k] = tsdf_pkg::CHAR_ZERO + 8'(v % 20'd10);
                v = v / 20'd10;
                k--;
            end while (v != 0 && k >= 0);
            for (k = 0; k < tsdf_pkg::NUM_DIGITS; k++) begin
                emit_char(digits[k]);
            end
            emit_char(tsdf_pkg::CHAR_TAB);
            if (int'(line_count) > max_line) begin
                max_line = int'(line_count);
            end
        end
        if (pcfg.mark_eol && c == tsdf_pkg::CHAR_NL) begin
            // Empty lines get a blank number field so the '$' column lines up.
            if (nb_mode && blank_seen) begin
                for (k = 0; k < tsdf_pkg::NUM_DIGITS; k++) begin
                    emit_char(tsdf_pkg::CHAR_SPACE);
                end
                emit_char(tsdf_pkg::CHAR_TAB);
            end
            emit_char(tsdf_pkg::CHAR_DOLLAR);
        end
        if (pcfg.caret_tab && c == tsdf_pkg::CHAR_TAB) begin
            emit_char(tsdf_pkg::CHAR_CARET);
            c = tsdf_pkg::CHAR_TAB + tsdf_pkg::CARET_SHIFT;
        end
        if (pcfg.show_nonprinting && c != tsdf_pkg::CHAR_NL && c != tsdf_pkg::CHAR_TAB) begin
            if (c < tsdf_pkg::CHAR_SPACE) begin
                emit_char(tsdf_pkg::CHAR_CARET);
                c = c + tsdf_pkg::CARET_SHIFT;
            end else if (c >= tsdf_pkg::CHAR_DEL) begin
                emit_char(tsdf_pkg::CHAR_CARET);
                c = c - tsdf_pkg::CARET_SHIFT;
            end
        end
        emit_char(c);
        // The stored byte is the rewritten one, which is never a newline unless c was.
        prev_char = c;
    endfunction

    // One register write. The predictor keeps only the bits each register holds.
    task write_reg(input logic [2:0] idx, input logic [1:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        case (idx)
            tsdf_pkg::CFG_NUMBER_MODE:      pcfg.number_mode = d;
            tsdf_pkg::CFG_SQUEEZE:          pcfg.squeeze_empty = d[0];
            tsdf_pkg::CFG_MARK_EOL:         pcfg.mark_eol = d[0];
            tsdf_pkg::CFG_CARET_TAB:        pcfg.caret_tab = d[0];
            tsdf_pkg::CFG_SHOW_NONPRINTING: pcfg.show_nonprinting = d[0];
            default: ;
        endcase
    endtask

    // Loads all five registers. The unused upper data bit of single-bit registers is random.
    task write_cfg(input tsdf_pkg::t_cfg c);
        write_reg(tsdf_pkg::CFG_NUMBER_MODE, c.number_mode);
        write_reg(tsdf_pkg::CFG_SQUEEZE, {1'($urandom_range(0, 1)), c.squeeze_empty});
        write_reg(tsdf_pkg::CFG_MARK_EOL, {1'($urandom_range(0, 1)), c.mark_eol});
        write_reg(tsdf_pkg::CFG_CARET_TAB, {1'($urandom_range(0, 1)), c.caret_tab});
        write_reg(tsdf_pkg::CFG_SHOW_NONPRINTING,
                  {1'($urandom_range(0, 1)), c.show_nonprinting});
        i_cfg_we <= 1'b0;
        n_phases++;
    endtask

    // Drops valid and holds off until every predicted byte has come out, then lets
    // settle more cycles pass so a squeezed newline still in flight can clear.
    // The loop waits on the clock before it checks, so valid is never lowered and raised in one step.
    task wait_drained(input int settle);
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (predicted_display_q.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // Offers one transaction, with a random gap at the start of each burst, waits for the
    // handshake and then queues the bytes the block owes for it.
    task send_item(input t_dir_row r);
        int gap;
        int k;
        t_disp_byte e;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_byte <= r.in_byte;
        i_file_start <= r.file_start;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_sent++;
        predict_display(r.in_byte, r.file_start);
        if (r.typed) begin
            line_out.delete();
            for (k = 0; k < int'(r.n_exp); k++) begin
                e.ch = r.exp_bytes[k];
                e.last = 1'b0;
                line_out.push_back(e);
            end
        end
        for (k = 0; k < line_out.size(); k++) begin
            e = line_out[k];
            e.last = (k == line_out.size() - 1);
            predicted_display_q.push_back(e);
        end
    endtask

    // Mostly text-like bytes with frequent runs of newlines so squeezing and blank-line
    // numbering get exercised; the rest is tabs, control bytes, high bytes and noise.
    function logic [7:0] next_text_byte();
        int r;
        if (nl_run > 0) begin
            nl_run--;
            return tsdf_pkg::CHAR_NL;
        end
        r = $urandom_range(0, 99);
        if (r < 44) begin
            return 8'($urandom_range(33, 126));
        end else if (r < 50) begin
            return tsdf_pkg::CHAR_SPACE;
        end else if (r < 62) begin
            return tsdf_pkg::CHAR_NL;
        end else if (r < 68) begin
            nl_run = $urandom_range(1, 4);
            return tsdf_pkg::CHAR_NL;
        end else if (r < 75) begin
            return tsdf_pkg::CHAR_TAB;
        end else if (r < 82) begin
            return 8'($urandom_range(0, 31));
        end else if (r < 89) begin
            return 8'($urandom_range(128, 255));
        end else if (r < 91) begin
            return tsdf_pkg::CHAR_DEL;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Receiver: ready follows a pattern that switches between always ready, light,
    // medium and heavy stalling, picked anew whenever the hold count runs out.
    always @(posedge i_clk) begin
        if (rx_hold_left == 0) begin
            rx_hold_left = $urandom_range(20, 80);
            rx_mode = $urandom_range(0, 3);
        end
        rx_hold_left--;
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2: i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Output checker: every output transaction is matched against the oldest predicted byte.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_display_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected output byte 0x%02h, last %0b, none predicted",
                             $time, o_out_byte, o_last);
                end
            end else begin
                seen_want = predicted_display_q.pop_front();
                n_checked++;
                if (o_out_byte !== seen_want.ch) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: out_byte mismatch: expected 0x%02h, actual 0x%02h",
                                 $time, seen_want.ch, o_out_byte);
                    end
                end
                if (o_last !== seen_want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, seen_want.last, o_last);
                    end
                end
            end
        end
    end

    // Watchdog, sized well above the slowest legal run with the heaviest stalling.
    initial begin
        #(3_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        tsdf_pkg::t_cfg c;
        t_dir_row r;
        int ph;
        int k;
        int pause_at;

        pcfg = '0;
        prev_char = tsdf_pkg::CHAR_NL;
        line_count = '0;
        blank_seen = 1'b0;

        // Reset configuration: bytes pass through untouched, the extremes included.
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, "A", 1'b0, 1'b1, "A"));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, 8'h00, 1'b0, 1'b0, ""));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, 8'hFF, 1'b0, 1'b1, "\377"));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, tsdf_pkg::CHAR_NL, 1'b0, 1'b1, "\n"));
        // Number all lines with every option but squeezing; a file start restarts the count.
        c = mk_cfg(2'd1, 1'b0, 1'b1, 1'b1, 1'b1);
        dir_rows.push_back(mk_row(1'b1, c, "x", 1'b1, 1'b1, "     1\tx"));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, tsdf_pkg::CHAR_TAB, 1'b0, 1'b1, "^I"));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, 8'h00, 1'b0, 1'b1, "^@"));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, 8'h7F, 1'b0, 1'b1, "^?"));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, 8'hFF, 1'b0, 1'b1, "^\277"));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, 8'h1F, 1'b0, 1'b1, "^_"));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, 8'h80, 1'b0, 1'b1, "^@"));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, tsdf_pkg::CHAR_NL, 1'b0, 1'b1, "$\n"));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, tsdf_pkg::CHAR_NL, 1'b0, 1'b1,
                                  "     2\t$\n"));
        // Non-blank numbering with squeezing and ends shown: padded empty line, then
        // squeezed newlines, then a numbered line.
        c = mk_cfg(2'd2, 1'b1, 1'b1, 1'b0, 1'b0);
        dir_rows.push_back(mk_row(1'b1, c, tsdf_pkg::CHAR_NL, 1'b1, 1'b1, "      \t$\n"));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, tsdf_pkg::CHAR_NL, 1'b0, 1'b0, ""));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, tsdf_pkg::CHAR_NL, 1'b0, 1'b0, ""));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, "q", 1'b0, 1'b1, "     1\tq"));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, tsdf_pkg::CHAR_NL, 1'b0, 1'b1, "$\n"));
        // Numbering mode three acts as non-blank numbering.
        c = mk_cfg(2'd3, 1'b0, 1'b0, 1'b1, 1'b0);
        dir_rows.push_back(mk_row(1'b1, c, tsdf_pkg::CHAR_TAB, 1'b0, 1'b1, "     2\t^I"));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, tsdf_pkg::CHAR_NL, 1'b0, 1'b1, "\n"));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, tsdf_pkg::CHAR_NL, 1'b0, 1'b1, "\n"));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, 8'h01, 1'b0, 1'b0, ""));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, "~", 1'b0, 1'b0, ""));
        // Squeezing alone: a file start clears the blank-line history.
        c = mk_cfg(2'd0, 1'b1, 1'b0, 1'b0, 1'b0);
        dir_rows.push_back(mk_row(1'b1, c, tsdf_pkg::CHAR_NL, 1'b1, 1'b0, ""));
        dir_rows.push_back(mk_row(1'b0, CFG_NONE, tsdf_pkg::CHAR_NL, 1'b0, 1'b0, ""));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A write to an index outside the map must leave every register alone.
        write_reg(CFG_SPARE_INDEX, 2'b11);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].new_cfg) begin
                wait_drained(DRAIN_CYCLES);
                write_cfg(dir_rows[i].cfg);
            end
            send_item(dir_rows[i]);
        end
        n_directed = n_sent;

        // Random phases: all options on, all off, then assorted settings. One phase runs
        // the sender without gaps, and each phase holds off once until the output drains.
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: c = mk_cfg(2'd3, 1'b1, 1'b1, 1'b1, 1'b1);
                1: c = mk_cfg(2'd0, 1'b0, 1'b0, 1'b0, 1'b0);
                2: c = mk_cfg(2'd1, 1'($urandom_range(0, 1)), 1'b1,
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                3: c = mk_cfg(2'd2, 1'b1, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                default: c = mk_cfg(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)));
            endcase
            wait_drained(DRAIN_CYCLES);
            write_cfg(c);
            no_gaps = (ph == 2);
            pause_at = $urandom_range(10, 45);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k == pause_at) begin
                    wait_drained(0);
                end
                r = '0;
                r.in_byte = next_text_byte();
                r.file_start = ($urandom_range(0, 31) == 0);
                send_item(r);
            end
        end

        wait_drained(DRAIN_CYCLES);

        $display("Run covered %0d input transactions (%0d directed) over %0d settings.",
                 n_sent, n_directed, n_phases);
        $display("Checked %0d output bytes; %0d newlines squeezed; line numbers up to %0d.",
                 n_checked, n_squeezed, max_line);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/tsdf_pkg.sv
src/tsdf_front.sv
src/tsdf_queue.sv
src/tsdf_back.sv
src/text_stream_display_filter.sv
verif/text_stream_display_filter_tb.sv
